// ===== rtl/afp_pkg.sv =====
// Package for the ADTS frame packetizer: channel word types, request and
// result codes, the sample rate table and the header constants.
// No dependencies.
`default_nettype none

package afp_pkg;

  localparam int HDR_LEN  = 7;
  localparam int BEAT_W   = $clog2(HDR_LEN);
  localparam logic [BEAT_W-1:0] HDR_LAST = BEAT_W'(HDR_LEN - 1);

  localparam int CFG_W    = 62;
  localparam int CFG_IDX_W = 3;
  localparam int RATES    = 12;

  localparam logic [7:0] ADTS_SYNC0    = 8'hFF;
  localparam logic [7:0] ADTS_SYNC1    = 8'hF1;
  localparam logic [1:0] ADTS_PROFILE  = 2'b01;
  localparam logic [4:0] ADTS_FULL_HI  = 5'h1F;
  localparam logic [7:0] ADTS_LAST     = 8'hFC;

  localparam logic [16:0] RATE_TABLE [RATES] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
    17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000
  };

  typedef enum logic [1:0] {
    REQ_FRAME  = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_PAUSE  = 2'd2,
    REQ_RESUME = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_BYTE        = 3'd0,
    KIND_PAUSED_DROP = 3'd1,
    KIND_CONFIG_DROP = 3'd2,
    KIND_SIZE_LIMIT  = 3'd3,
    KIND_DUR_LIMIT   = 3'd4,
    KIND_BAD_RATE    = 3'd5,
    KIND_STOPPED     = 3'd6
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE  = 3'd0,
    CFG_CHANNELS     = 3'd1,
    CFG_MAX_SIZE     = 3'd2,
    CFG_MAX_DURATION = 3'd3,
    CFG_FRAME_DUR    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [12:0] payload_length;
    logic [61:0] timestamp_us;
    logic        codec_config;
    logic [7:0]  payload_byte;
  } afp_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  out_kind;
    logic        last;
    logic [47:0] size_so_far;
  } afp_out_t;

  typedef struct packed {
    logic [16:0] sample_rate_hz;
    logic [1:0]  channel_count;
    logic [47:0] max_size_bytes;
    logic [61:0] max_duration_us;
    logic [19:0] frame_duration_us;
  } afp_cfg_t;

  // Result descriptor handed from the frame logic to the output stage.
  typedef struct packed {
    logic        valid;
    logic        hdr;
    logic [7:0]  data;
    kind_t       kind;
    logic [47:0] size;
    logic [3:0]  freq_idx;
    logic [1:0]  chan;
    logic [12:0] flen;
  } afp_desc_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } rate_hit_t;

  function automatic rate_hit_t rate_lookup(input logic [16:0] rate);
    rate_hit_t hit;
    hit = '0;
    for (int i = RATES - 1; i >= 0; i--) begin
      if (rate == RATE_TABLE[i]) begin
        hit.found = 1'b1;
        hit.idx   = 4'(i);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/adts_frame_packetizer.sv =====
// ADTS frame packetizer, top level. Ties together the configuration
// registers, input register, frame logic and output stage. Depends on afp_pkg.
//
// Usage: words arrive on in_valid/in_ready/in_data: frame start, payload
// byte, pause or resume. Results leave on out_valid/out_ready/out_data, one
// word per result. A frame start that passes all checks gives seven header
// bytes, with last set on the seventh; its payload bytes then pass through
// one result each. Drops, limit stops, a bad rate and words after a stop give
// one status word each. Pause, resume and dropped or stray bytes give none.
// A result passes the input register, then the output register. While the
// receiver is ready, throughput is one word per cycle for payload bytes and
// single-result words; a header holds the output for its seven bytes, while
// one further word waits in the input register. A stalled receiver freezes
// the output register; the input register then fills and in_ready drops.
// Configuration is written through cfg_we, cfg_index and cfg_wdata by the user
// only while the block is idle (not enforced). Synchronous reset clears all
// stream state and loads the default configuration; no clearing pass.
`default_nettype none

module adts_frame_packetizer
  import afp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  afp_in_t                   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output afp_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  afp_cfg_t  cfg;
  logic      held_valid;
  afp_in_t   held_data;
  logic      out_free;
  logic      fire;
  afp_desc_t desc;

  assign fire = held_valid && out_free;

  afp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (fire),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  afp_frame_logic u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (held_data),
    .cfg   (cfg),
    .desc  (desc)
  );

  afp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .desc      (desc),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/afp_cfg_regs.sv =====
// Configuration register file of the ADTS frame packetizer.
// Depends on afp_pkg for the register codes and the afp_cfg_t bundle.
`default_nettype none

module afp_cfg_regs
  import afp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output afp_cfg_t                  cfg
);

  afp_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_RATE:  cfg_nxt.sample_rate_hz    = cfg_wdata[16:0];
        CFG_CHANNELS:     cfg_nxt.channel_count     = cfg_wdata[1:0];
        CFG_MAX_SIZE:     cfg_nxt.max_size_bytes    = cfg_wdata[47:0];
        CFG_MAX_DURATION: cfg_nxt.max_duration_us   = cfg_wdata[61:0];
        CFG_FRAME_DUR:    cfg_nxt.frame_duration_us = cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate_hz    <= 17'd44100;
      cfg_r.channel_count     <= 2'd2;
      cfg_r.max_size_bytes    <= '0;
      cfg_r.max_duration_us   <= '0;
      cfg_r.frame_duration_us <= 20'd23220;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/afp_in_reg.sv =====
// Input register of the ADTS frame packetizer: holds one accepted word
// until the frame logic takes it. Depends on afp_pkg for afp_in_t.
`default_nettype none

module afp_in_reg
  import afp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  afp_in_t   in_data,
  input  wire logic take,
  output logic      held_valid,
  output afp_in_t   held_data
);

  logic    valid_r, valid_nxt;
  afp_in_t data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

  assign held_valid = valid_r;
  assign held_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/afp_frame_logic.sv =====
// Frame logic of the ADTS frame packetizer: stream state, size and duration
// limits, pause handling and rate lookup. Produces at most one result
// descriptor per processed word. Depends on afp_pkg.
`default_nettype none

module afp_frame_logic
  import afp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  afp_in_t   item,
  input  afp_cfg_t  cfg,
  output afp_desc_t desc
);

  logic        paused_r, paused_nxt;
  logic        resumed_r, resumed_nxt;
  logic        stopped_r, stopped_nxt;
  logic        pass_r, pass_nxt;
  logic [12:0] left_r, left_nxt;
  logic [47:0] est_size_r, est_size_nxt;
  logic [61:0] est_dur_r, est_dur_nxt;
  logic [63:0] max_adj_r, max_adj_nxt;
  logic [63:0] pause_off_r, pause_off_nxt;

  logic [13:0] add_len;
  logic [48:0] size_sum;
  logic [47:0] size_sat;
  logic        size_stop;
  logic        dur_stop;
  logic [63:0] ts64;
  logic [63:0] off_resumed;
  logic [63:0] adj;
  logic        adj_gt;
  rate_hit_t   hit;

  assign add_len  = 14'(item.payload_length) + 14'(HDR_LEN);
  assign size_sum = {1'b0, est_size_r} + 49'(add_len);
  assign size_sat = size_sum[48] ? '1 : size_sum[47:0];
  assign size_stop = (cfg.max_size_bytes != '0) && (size_sat >= cfg.max_size_bytes);
  // The running maximum reaches the limit if either operand does.
  assign dur_stop = (cfg.max_duration_us != '0) &&
                    ((item.timestamp_us >= cfg.max_duration_us) ||
                     (est_dur_r >= cfg.max_duration_us));
  assign ts64        = {2'b00, item.timestamp_us};
  assign off_resumed = pause_off_r + ts64 - max_adj_r - 64'(cfg.frame_duration_us);
  // After a resume the timestamp cancels out of the adjusted time, which
  // keeps the compare below off the end of the offset sum.
  assign adj         = resumed_r ?
                       (max_adj_r + 64'(cfg.frame_duration_us) - pause_off_r) :
                       (ts64 - pause_off_r);
  assign adj_gt      = $signed(adj) > $signed(max_adj_r);
  assign hit         = rate_lookup(cfg.sample_rate_hz);

  always_comb begin
    paused_nxt    = paused_r;
    resumed_nxt   = resumed_r;
    stopped_nxt   = stopped_r;
    pass_nxt      = pass_r;
    left_nxt      = left_r;
    est_size_nxt  = est_size_r;
    est_dur_nxt   = est_dur_r;
    max_adj_nxt   = max_adj_r;
    pause_off_nxt = pause_off_r;

    desc          = '0;
    desc.kind     = KIND_BYTE;
    desc.freq_idx = hit.idx;
    desc.chan     = cfg.channel_count;
    desc.flen     = add_len[12:0];

    if (fire) begin
      if (stopped_r) begin
        desc.valid = 1'b1;
        desc.kind  = KIND_STOPPED;
      end else begin
        case (req_t'(item.req_type))
          REQ_PAUSE: begin
            paused_nxt = 1'b1;
          end
          REQ_RESUME: begin
            if (paused_r) begin
              paused_nxt  = 1'b0;
              resumed_nxt = 1'b1;
            end
          end
          REQ_BYTE: begin
            if (left_r != '0) begin
              left_nxt = left_r - 13'd1;
              if (pass_r) begin
                desc.valid = 1'b1;
                desc.data  = item.payload_byte;
              end
            end
          end
          default: begin
            left_nxt = item.payload_length;
            pass_nxt = 1'b0;
            desc.valid = 1'b1;
            if (paused_r) begin
              desc.kind = KIND_PAUSED_DROP;
            end else begin
              est_size_nxt = size_sat;
              if (size_stop) begin
                stopped_nxt = 1'b1;
                left_nxt    = '0;
                desc.kind   = KIND_SIZE_LIMIT;
              end else if (item.codec_config) begin
                desc.kind = KIND_CONFIG_DROP;
              end else begin
                if (item.timestamp_us > est_dur_r) begin
                  est_dur_nxt = item.timestamp_us;
                end
                if (resumed_r) begin
                  pause_off_nxt = off_resumed;
                  resumed_nxt   = 1'b0;
                end
                if (adj_gt) begin
                  max_adj_nxt = adj;
                end
                if (dur_stop) begin
                  stopped_nxt = 1'b1;
                  left_nxt    = '0;
                  desc.kind   = KIND_DUR_LIMIT;
                end else if (!hit.found) begin
                  stopped_nxt = 1'b1;
                  left_nxt    = '0;
                  desc.kind   = KIND_BAD_RATE;
                end else begin
                  desc.hdr = 1'b1;
                  pass_nxt = 1'b1;
                end
              end
            end
          end
        endcase
      end
    end
    desc.size = est_size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r    <= 1'b0;
      resumed_r   <= 1'b0;
      stopped_r   <= 1'b0;
      pass_r      <= 1'b0;
      left_r      <= '0;
      est_size_r  <= '0;
      est_dur_r   <= '0;
      max_adj_r   <= '0;
      pause_off_r <= '0;
    end else begin
      paused_r    <= paused_nxt;
      resumed_r   <= resumed_nxt;
      stopped_r   <= stopped_nxt;
      pass_r      <= pass_nxt;
      left_r      <= left_nxt;
      est_size_r  <= est_size_nxt;
      est_dur_r   <= est_dur_nxt;
      max_adj_r   <= max_adj_nxt;
      pause_off_r <= pause_off_nxt;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped state was left without reset");

  a_stop_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (!pass_r && left_r == '0))
    else $error("payload still pending after stop");

  a_size_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (est_size_r >= $past(est_size_r)))
    else $error("estimated size decreased");

endmodule

`default_nettype wire

// ===== rtl/afp_out_stage.sv =====
// Output register and header sequencer of the ADTS frame packetizer. A
// header descriptor is played out as seven bytes. Depends on afp_pkg.
`default_nettype none

module afp_out_stage
  import afp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  afp_desc_t desc,
  output logic      free,
  output logic      out_valid,
  input  wire logic out_ready,
  output afp_out_t  out_data
);

  logic              valid_r, valid_nxt;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  afp_desc_t         desc_r;
  logic              final_beat;
  logic [7:0]        hdr_byte;

  assign final_beat = !desc_r.hdr || (beat_r == HDR_LAST);
  assign free       = !valid_r || (out_ready && final_beat);

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (free) begin
      valid_nxt = fire && desc.valid;
      beat_nxt  = '0;
    end else if (out_ready) begin
      beat_nxt = beat_r + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      desc_r <= desc;
    end
  end

  always_comb begin
    case (beat_r)
      3'd0:    hdr_byte = ADTS_SYNC0;
      3'd1:    hdr_byte = ADTS_SYNC1;
      3'd2:    hdr_byte = {ADTS_PROFILE, desc_r.freq_idx, 2'b00};
      3'd3:    hdr_byte = {desc_r.chan, 4'b0000, desc_r.flen[12:11]};
      3'd4:    hdr_byte = desc_r.flen[10:3];
      3'd5:    hdr_byte = {desc_r.flen[2:0], ADTS_FULL_HI};
      3'd6:    hdr_byte = ADTS_LAST;
      default: hdr_byte = 8'h00;
    endcase
  end

  assign out_valid            = valid_r;
  assign out_data.out_byte    = desc_r.hdr ? hdr_byte : desc_r.data;
  assign out_data.out_kind    = desc_r.kind;
  assign out_data.last        = final_beat;
  assign out_data.size_so_far = desc_r.size;

  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (beat_r <= HDR_LAST))
    else $error("header beat counter out of range");

  a_single_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !desc_r.hdr) |-> (beat_r == '0))
    else $error("beat counter moved on a single-word result");

  a_hdr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && desc_r.hdr && out_ready && !final_beat) |=>
      (valid_r && beat_r == $past(beat_r) + BEAT_W'(1)))
    else $error("header sequence skipped or lost a byte");

endmodule

`default_nettype wire
